// ===== hdl/sitda_pkg.sv =====
// sitda_pkg: shared constants and controller/datapath types for the
// signed integer to decimal ascii converter. No dependencies.
`default_nettype none
package sitda_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int CHAR_WIDTH        = 6;
   localparam int NUM_DIGITS        = 10;
   localparam int BCD_WIDTH         = 4 * NUM_DIGITS;
   localparam int SHIFT_COUNT_WIDTH = 5;
   localparam int DIGIT_INDEX_WIDTH = 4;

   localparam logic [SHIFT_COUNT_WIDTH-1:0] LAST_SHIFT = 5'd31;
   localparam logic [CHAR_WIDTH-1:0]        CHAR_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0]        CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0]        CHAR_NINE  = 6'd57;

   typedef struct packed {
      logic load;
      logic shift;
      logic locate;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic shift_done;
      logic negative;
      logic final_digit;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/sitda_if.sv =====
// sitda_if: valid/ready channel interfaces for the request and response
// sides. Depends on sitda_pkg.
`default_nettype none
interface sitda_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sitda_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sitda_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sitda_pkg::CHAR_WIDTH-1:0]   char_code;
   logic                               last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/sitda_datapath.sv =====
// sitda_datapath: magnitude, shift-add-3 bcd conversion, digit index and
// response character register. Depends on sitda_pkg.
`default_nettype none
module sitda_datapath (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire sitda_pkg::cmd_type                   cmd,
   input  wire logic signed [sitda_pkg::VALUE_WIDTH-1:0] value,
   output sitda_pkg::status_type                     status,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]          char_code,
   output logic                                      last
);

   logic [sitda_pkg::VALUE_WIDTH-1:0]       mag_ff, mag_in;
   logic [sitda_pkg::BCD_WIDTH-1:0]         bcd_ff, bcd_in, bcd_adj;
   logic [sitda_pkg::SHIFT_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [sitda_pkg::DIGIT_INDEX_WIDTH-1:0] idx_ff, idx_in, msd;
   logic                                    neg_ff, neg_in;
   logic [sitda_pkg::CHAR_WIDTH-1:0]        char_ff, char_in;
   logic                                    last_ff, last_in;
   logic [3:0]                              digit;

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // most significant non-zero digit, zero when all digits are zero
   always_comb begin
      msd = '0;
      for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            msd = i[sitda_pkg::DIGIT_INDEX_WIDTH-1:0];
         end
      end
   end

   assign digit = bcd_ff[4*idx_ff +: 4];

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      neg_in  = neg_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in = value[sitda_pkg::VALUE_WIDTH-1];
         mag_in = value[sitda_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.shift) begin
         bcd_in = {bcd_adj[sitda_pkg::BCD_WIDTH-2:0], mag_ff[sitda_pkg::VALUE_WIDTH-1]};
         mag_in = {mag_ff[sitda_pkg::VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.locate) begin
         idx_in = msd;
      end
      if (cmd.emit_sign) begin
         char_in = sitda_pkg::CHAR_MINUS;
         last_in = 1'b0;
      end
      if (cmd.emit_digit) begin
         char_in = sitda_pkg::CHAR_ZERO + {2'b00, digit};
         last_in = (idx_ff == '0);
         idx_in  = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
         neg_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         neg_ff <= neg_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.shift_done  = (cnt_ff == sitda_pkg::LAST_SHIFT);
   assign status.negative    = neg_ff;
   assign status.final_digit = (idx_ff == '0);
   assign char_code          = char_ff;
   assign last               = last_ff;

endmodule
`default_nettype wire

// ===== hdl/sitda_controller.sv =====
// sitda_controller: state machine sequencing load, conversion, sign and
// digit output, and owning the response valid flag. Depends on sitda_pkg.
`default_nettype none
module sitda_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  wire sitda_pkg::status_type status,
   output sitda_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CONVERT = 3'd1;
   localparam logic [2:0] ST_LOCATE  = 3'd2;
   localparam logic [2:0] ST_SIGN    = 3'd3;
   localparam logic [2:0] ST_DIGITS  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            cmd.locate = 1'b1;
            state_in   = status.negative ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (slot_free) begin
               cmd.emit_digit = 1'b1;
               if (status.final_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit_sign || cmd.emit_digit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// signed_int_to_decimal_ascii: one signed 32-bit value in, its decimal text
// out as one transaction per character, most significant first.
// load, shift-add-3 over all 32 bits and locate come first, then 1 to 11
// characters, one per cycle while accepted; a new value waits for the last.
// reset (synchronous, active high) idles the controller, no response pending.
// Depends on sitda_pkg, sitda_if, sitda_datapath, sitda_controller.
`default_nettype none
module signed_int_to_decimal_ascii (
   input  wire          clock,
   input  wire          reset,
   sitda_req_if.sink    req,
   sitda_rsp_if.source  rsp
);

   sitda_pkg::cmd_type    cmd;
   sitda_pkg::status_type status;

   sitda_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sitda_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .value     (req.value),
      .status    (status),
      .char_code (rsp.char_code),
      .last      (rsp.last)
   );

   // a pending response while idle is the final character of the last value
   a_idle_pending_last: assert property (@(posedge clock) disable iff (reset)
      req.ready && rsp.valid |-> rsp.last)
      else $error("pending response while idle is not marked last");

   // the minus sign never ends a run
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.char_code == sitda_pkg::CHAR_MINUS |-> !rsp.last)
      else $error("minus sign marked last");

   // only the minus sign and decimal digits appear
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.char_code == sitda_pkg::CHAR_MINUS ||
         (rsp.char_code >= sitda_pkg::CHAR_ZERO && rsp.char_code <= sitda_pkg::CHAR_NINE))
      else $error("character code out of range");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for signed_int_to_decimal_ascii, directed table then
// random values under varying idle and stall pressure, checked character by character.
// Depends on sitda_pkg, sitda_if and the signed_int_to_decimal_ascii rtl.
module testbench;

   typedef struct packed {
      logic [sitda_pkg::CHAR_WIDTH-1:0] char_code;
      logic                             last;
   } text_char_type;

   typedef struct {
      logic [sitda_pkg::VALUE_WIDTH-1:0] value;
      string                             text;
   } directed_row_type;

   localparam int RANDOM_PER_PHASE = 80;
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 60;
   localparam int NUM_ROWS         = 22;
   localparam int NUM_PHASES       = 4;

   logic clock = 1'b0;
   logic reset;

   sitda_req_if req_ch ();
   sitda_rsp_if rsp_ch ();

   signed_int_to_decimal_ascii dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   text_char_type pending_chars[$];
   int            error_count   = 0;
   int            req_idle_pct  = 0;
   int            rsp_stall_pct = 0;
   logic          hold_request  = 1'b0;

   directed_row_type rows[NUM_ROWS] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'hFFFF_FFFF,  "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'sd10,       "-10"},
      '{32'd99,         "99"},
      '{32'd100,        "100"},
      '{-32'sd100,      "-100"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{-32'sd999999999, "-999999999"},
      '{32'd123456789,  ""},
      '{-32'sd987654321, ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'h0000_8000,  ""},
      '{32'hEE6B_2800,  ""},
      '{32'd7,          ""}
   };
   int idle_table[NUM_PHASES]  = '{0, 57, 0, 36};
   int stall_table[NUM_PHASES] = '{0, 0, 57, 36};

   // expected text, most significant digit first
   function automatic void predict_text(input logic [sitda_pkg::VALUE_WIDTH-1:0] word);
      logic [sitda_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [3:0]                        digit_stack[sitda_pkg::NUM_DIGITS];
      int                                count;
      magnitude = word[sitda_pkg::VALUE_WIDTH-1] ? (~word + 32'd1) : word;
      count = 0;
      do begin
         digit_stack[count] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         count++;
      end while (magnitude != 0);
      if (word[sitda_pkg::VALUE_WIDTH-1])
         pending_chars.push_back('{char_code: sitda_pkg::CHAR_MINUS, last: 1'b0});
      for (int k = count - 1; k >= 0; k--)
         pending_chars.push_back('{char_code: sitda_pkg::CHAR_ZERO +
                                      sitda_pkg::CHAR_WIDTH'(digit_stack[k]),
                                   last: (k == 0)});
   endfunction

   function automatic void expect_literal(input string text);
      byte ch;
      for (int i = 0; i < text.len(); i++) begin
         ch = text[i];
         pending_chars.push_back('{char_code: ch[sitda_pkg::CHAR_WIDTH-1:0],
                                   last: (i == text.len() - 1)});
      end
   endfunction

   // mostly values of a chosen digit count, the rest full-range words
   function automatic logic [sitda_pkg::VALUE_WIDTH-1:0] random_value();
      int                                ndigits;
      longint                            lo;
      longint                            hi;
      logic [sitda_pkg::VALUE_WIDTH-1:0] magnitude;
      if ($urandom_range(99) < 30)
         return $urandom;
      ndigits = $urandom_range(sitda_pkg::NUM_DIGITS, 1);
      lo = 1;
      for (int i = 1; i < ndigits; i++)
         lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndigits == 1)
         lo = 0;
      if (hi > 64'd2147483647)
         hi = 64'd2147483647;
      magnitude = $urandom_range(32'(hi), 32'(lo));
      return $urandom_range(1) ? (~magnitude + 32'd1) : magnitude;
   endfunction

   task automatic offer_value(input logic [sitda_pkg::VALUE_WIDTH-1:0] word,
                              input string text);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= $urandom;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= word;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (text.len() != 0)
         expect_literal(text);
      else
         predict_text(word);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int   hold_left;
      logic hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected transaction: char_code %0d last %0b",
                        rsp_ch.char_code, rsp_ch.last);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_ch.char_code !== want.char_code || rsp_ch.last !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: expected char_code %0d last %0b, ",
                            "got char_code %0d last %0b"},
                           want.char_code, want.last, rsp_ch.char_code, rsp_ch.last);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         offer_value(rows[i].value, rows[i].text);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_idle_pct  = idle_table[phase];
         rsp_stall_pct = stall_table[phase];
         if (phase == 0)
            hold_request = 1'b1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            offer_value(random_value(), "");
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_chars.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
